// ----- rtl/spfs_pkg.sv -----
// ----------------------------------------------------------------------------
// spfs_pkg: shared constants and codes of the slot pool
// Pool size, entry width, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spfs_pkg;

	localparam int SLOTS      = 64;
	localparam int ENTRY_BITS = 32;

	// index into the pool, and a count that can hold SLOTS itself
	localparam int ADDR_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// beat field widths
	localparam int OP_W    = 2;
	localparam int IDX_W   = 10;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int GRANT_W = 6;
	localparam int USED_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FREE  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/spfs_if.sv -----
// ----------------------------------------------------------------------------
// spfs_if: request and response channels of the slot pool
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface spfs_req_if;
	logic                      valid;
	logic                      ready;
	logic [spfs_pkg::OP_W-1:0]   op;
	logic [spfs_pkg::IDX_W-1:0]  slot_index;
	logic [spfs_pkg::DATA_W-1:0] write_data;
	logic                      data_present;

	modport source (output valid, output op, output slot_index, output write_data,
		output data_present, input ready);
	modport sink (input valid, input op, input slot_index, input write_data,
		input data_present, output ready);
endinterface

interface spfs_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [spfs_pkg::STAT_W-1:0]  status;
	logic [spfs_pkg::GRANT_W-1:0] granted_index;
	logic [spfs_pkg::DATA_W-1:0]  read_data;
	logic [spfs_pkg::USED_W-1:0]  used_count;

	modport source (output valid, output status, output granted_index,
		output read_data, output used_count, input ready);
	modport sink (input valid, input status, input granted_index,
		input read_data, input used_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/slot_pool_free_stack.sv -----
// ----------------------------------------------------------------------------
// slot_pool_free_stack: fixed pool of data slots with a LIFO free list
// Allocate, read and release slots; one response beat per request beat.
// ----------------------------------------------------------------------------
// Usage
//   req carries one operation per beat: allocate (pops the top free index,
//   stores write_data or zero there and returns the index), read (returns
//   the slot contents) or release (pushes the index back and zeroes the
//   slot, unless it is already free). rsp returns one beat per request
//   with status, granted_index, read_data and the count of used slots.
//   Each request passes through the steps accept, memory fetch and
//   execute/commit before its response beat is offered. A new request is
//   accepted only once the last one has executed: the sequencer walks each
//   request through the single depth adder and the one read port of each memory.
//   The response sits in an output register; while it waits, the next
//   request is accepted and fetched, and its execute step holds until the
//   output register is free, so a stalled receiver stalls the pool after
//   at most one further request.
//   Reset: slot store reads as zero and the free list as full, via per
//   entry written bits cleared at once; no clearing pass is needed, and
//   req.ready is high as soon as reset is released.
//   Per-slot free bits answer the "already free" check of a release.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_free_stack (
	input  wire         clk,
	input  wire         arst_n,
	spfs_req_if.sink    req,
	spfs_rsp_if.source  rsp
);
	import spfs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	// captured request
	logic [OP_W-1:0]       op_q;
	logic [ADDR_W-1:0]     idx_q;
	logic                  oor_q;
	logic [ENTRY_BITS-1:0] wdata_q;

	// free list depth and the shared depth adder result
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] depth_nx_q;
	logic [CNT_W-1:0] adder_sum;

	// memories and their written/free bits
	logic [ENTRY_BITS-1:0] slot_mem [SLOTS];
	logic [ADDR_W-1:0]     stk_mem  [SLOTS];
	logic [SLOTS-1:0]      slot_wr_q;
	logic [SLOTS-1:0]      stk_wr_q;
	logic [SLOTS-1:0]      free_q;

	// fetch stage results
	logic [ENTRY_BITS-1:0] slot_rd_s1;
	logic                  slot_vld_s1;
	logic [ADDR_W-1:0]     stk_rd_s1;
	logic                  stk_vld_s1;
	logic [ADDR_W-1:0]     stk_def_s1;
	logic                  free_hit_s1;
	logic                  empty_s1;
	logic [ADDR_W-1:0]     stk_ra;

	// execute decisions
	logic                  out_free;
	logic                  exec_go;
	logic [ADDR_W-1:0]     grant;
	logic                  commit;
	status_t               status_d;
	logic [DATA_W-1:0]     rdata_d;
	logic [GRANT_W-1:0]    grant_d;
	logic [CNT_W-1:0]      depth_after;
	logic                  slot_we;
	logic [ADDR_W-1:0]     slot_wa;
	logic [ENTRY_BITS-1:0] slot_wd;
	logic                  stk_we;
	logic [ADDR_W-1:0]     stk_wa;
	logic                  free_set;
	logic                  free_clr;

	// response register
	logic                  rsp_vld_q;
	logic [STAT_W-1:0]     status_q;
	logic [GRANT_W-1:0]    grant_q;
	logic [DATA_W-1:0]     rdata_q;
	logic [USED_W-1:0]     used_q;

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign exec_go   = (state_q == S_EXEC) && out_free;

	// shared depth adder: step down for allocate, up otherwise
	assign adder_sum = depth_q + ((op_q == OP_ALLOC) ? {CNT_W{1'b1}} : CNT_W'(1));
	assign stk_ra    = adder_sum[ADDR_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// capture the request beat
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			idx_q   <= req.slot_index[ADDR_W-1:0];
			oor_q   <= ({1'b0, req.slot_index} >= (IDX_W + 1)'(SLOTS));
			wdata_q <= req.data_present ? ENTRY_BITS'(req.write_data) : '0;
		end
	end

	// fetch: one read of each memory, registered
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			slot_rd_s1  <= slot_mem[idx_q];
			stk_rd_s1   <= stk_mem[stk_ra];
			depth_nx_q  <= adder_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			slot_vld_s1 <= slot_wr_q[idx_q];
			stk_vld_s1  <= stk_wr_q[stk_ra];
			stk_def_s1  <= ADDR_W'(SLOTS - 1) - stk_ra;
			free_hit_s1 <= free_q[idx_q];
			empty_s1    <= (depth_q == '0);
		end
	end

	// execute: decide the outcome and the memory writes
	assign grant = stk_vld_s1 ? stk_rd_s1 : stk_def_s1;

	always_comb begin
		status_d = ST_OK;
		rdata_d  = '0;
		grant_d  = '0;
		commit   = 1'b0;
		slot_we  = 1'b0;
		slot_wa  = idx_q;
		slot_wd  = '0;
		stk_we   = 1'b0;
		stk_wa   = depth_q[ADDR_W-1:0];
		free_set = 1'b0;
		free_clr = 1'b0;
		unique case (op_t'(op_q))
			OP_ALLOC: begin
				if (empty_s1) begin
					status_d = ST_FULL;
				end else begin
					grant_d  = GRANT_W'(grant);
					commit   = 1'b1;
					slot_we  = 1'b1;
					slot_wa  = grant;
					slot_wd  = wdata_q;
					free_clr = 1'b1;
				end
			end
			OP_READ: begin
				if (oor_q) begin
					status_d = ST_RANGE;
				end else if (slot_vld_s1) begin
					rdata_d = DATA_W'(slot_rd_s1);
				end
			end
			OP_RELEASE: begin
				if (oor_q) begin
					status_d = ST_RANGE;
				end else if (free_hit_s1) begin
					status_d = ST_FREE;
				end else begin
					commit   = 1'b1;
					slot_we  = 1'b1;
					stk_we   = 1'b1;
					free_set = 1'b1;
				end
			end
			default: begin
				// unused code: report the current state, change nothing
			end
		endcase
	end

	assign depth_after = commit ? depth_nx_q : depth_q;

	// memory writes
	always_ff @(posedge clk) begin
		if (exec_go && slot_we) slot_mem[slot_wa] <= slot_wd;
		if (exec_go && stk_we)  stk_mem[stk_wa]   <= idx_q;
	end

	// written bits, free bits and depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_wr_q <= '0;
			stk_wr_q  <= '0;
			free_q    <= '1;
			depth_q   <= CNT_W'(SLOTS);
		end else if (exec_go) begin
			if (slot_we)  slot_wr_q[slot_wa] <= 1'b1;
			if (stk_we)   stk_wr_q[stk_wa]   <= 1'b1;
			if (free_set) free_q[idx_q]      <= 1'b1;
			if (free_clr) free_q[grant]      <= 1'b0;
			if (commit)   depth_q            <= depth_nx_q;
		end
	end

	// response register: load on execute, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (exec_go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= status_d;
			grant_q  <= grant_d;
			rdata_q  <= rdata_d;
			used_q   <= USED_W'(CNT_W'(SLOTS) - depth_after);
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = status_q;
	assign rsp.granted_index = grant_q;
	assign rsp.read_data     = rdata_q;
	assign rsp.used_count    = used_q;

	// free bits and the free list depth always agree
	a_depth_matches_free: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(free_q) == int'(depth_q))
		else $error("free list depth differs from free bit count");

	// an allocate only ever hands out a slot that is free
	a_grant_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && free_clr) |-> free_q[grant])
		else $error("allocate granted a slot that is not free");

	// a release is pushed only onto a list that has room
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && stk_we) |-> (depth_q < CNT_W'(SLOTS)))
		else $error("release pushed onto a full free list");

endmodule

`default_nettype wire
